/* rtl/core/tbt_pkg.sv */
// shared types and constants of the text bounding box tracker
package tbt_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_START  = 2'd1,
        ACT_CHAR   = 2'd2,
        ACT_FINISH = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        CFG_SCALE_X      = 3'd0,
        CFG_SCALE_Y      = 3'd1,
        CFG_CUSTOM_FONT  = 3'd2,
        CFG_FIRST_CHAR   = 3'd3,
        CFG_LAST_CHAR    = 3'd4,
        CFG_LINE_ADVANCE = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic              [7:0] w;
        logic              [7:0] h;
        logic              [7:0] adv;
        logic signed       [7:0] ox;
        logic signed       [7:0] oy;
    } t_glyph;

    typedef struct packed {
        logic [7:0] scale_x;
        logic [7:0] scale_y;
        logic       use_custom_font;
        logic [7:0] first_char;
        logic [7:0] last_char;
        logic [7:0] line_advance;
    } t_cfg;

    typedef struct packed {
        logic [15:0] left_x;
        logic [15:0] top_y;
        logic [15:0] box_width;
        logic [15:0] box_height;
        logic [15:0] final_x;
        logic [15:0] final_y;
    } t_result;

    localparam logic [7:0]  CHAR_NEWLINE = 8'd10;
    localparam logic [7:0]  CHAR_RETURN  = 8'd13;
    localparam logic [7:0]  CELL_W       = 8'd6;
    localparam logic [7:0]  CELL_H       = 8'd8;
    localparam logic [15:0] LEAST_INIT   = 16'h7FFF;
    localparam logic [15:0] GREAT_INIT   = 16'h8001;

    localparam logic [7:0] RST_SCALE       = 8'd1;
    localparam logic [7:0] RST_FIRST_CHAR  = 8'd32;
    localparam logic [7:0] RST_LAST_CHAR   = 8'd126;
    localparam logic [7:0] RST_LINE_ADV    = 8'd8;

endpackage

/* rtl/core/tbt_glyph_ram.sv */
// glyph metrics memory, one write and one registered read port
module tbt_glyph_ram #(
    parameter int ENTRIES = 256,
    parameter int AW      = 8
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  tbt_pkg::t_glyph     i_wdata,
    input  logic                i_re,
    input  logic [AW-1:0]       i_raddr,
    output tbt_pkg::t_glyph     o_rdata
);

    tbt_pkg::t_glyph r_mem [ENTRIES];
    tbt_pkg::t_glyph r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/tbt_box_core.sv */
// cursor and box extremes state with the per-word update and finish report
module tbt_box_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  tbt_pkg::t_action    i_act,
    input  logic [7:0]          i_char,
    input  logic [15:0]         i_start_x,
    input  logic [15:0]         i_start_y,
    input  tbt_pkg::t_glyph     i_glyph,
    input  logic                i_glyph_ok,
    input  tbt_pkg::t_cfg       i_cfg,
    output tbt_pkg::t_result    o_result
);

    logic signed [15:0] r_cur_x, r_cur_y, r_org_x, r_org_y;
    logic signed [15:0] r_lx, r_ly, r_gx, r_gy;
    logic signed [15:0] n_cur_x, n_cur_y, n_org_x, n_org_y;
    logic signed [15:0] n_lx, n_ly, n_gx, n_gy;

    tbt_pkg::t_glyph    g;
    logic               in_range;
    logic signed [15:0] prod_ox, prod_oy;
    logic [15:0]        prod_w, prod_h, prod_adv, line_step;
    logic signed [15:0] x1, y1, x2, y2;
    logic [7:0]         line_unit;

    // glyph rectangle and cursor advance
    always_comb begin
        g = i_glyph_ok ? i_glyph : '0;
        if (!i_cfg.use_custom_font) begin
            g.w   = tbt_pkg::CELL_W;
            g.h   = tbt_pkg::CELL_H;
            g.adv = tbt_pkg::CELL_W;
            g.ox  = '0;
            g.oy  = '0;
        end
        in_range = !i_cfg.use_custom_font ||
                   ((i_char >= i_cfg.first_char) && (i_char <= i_cfg.last_char));
        // offset times scale always fits in 16 signed bits
        prod_ox  = 16'($signed(g.ox)) * 16'($signed({1'b0, i_cfg.scale_x}));
        prod_oy  = 16'($signed(g.oy)) * 16'($signed({1'b0, i_cfg.scale_y}));
        prod_w   = 16'(g.w) * 16'(i_cfg.scale_x);
        prod_h   = 16'(g.h) * 16'(i_cfg.scale_y);
        prod_adv = 16'(g.adv) * 16'(i_cfg.scale_x);
        x1 = r_cur_x + prod_ox[15:0];
        y1 = r_cur_y + prod_oy[15:0];
        x2 = x1 + prod_w - 16'd1;
        y2 = y1 + prod_h - 16'd1;
        line_unit = i_cfg.use_custom_font ? i_cfg.line_advance : tbt_pkg::CELL_H;
        line_step = 16'(line_unit) * 16'(i_cfg.scale_y);
    end

    always_comb begin
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        n_org_x = r_org_x;
        n_org_y = r_org_y;
        n_lx    = r_lx;
        n_ly    = r_ly;
        n_gx    = r_gx;
        n_gy    = r_gy;
        case (i_act)
            tbt_pkg::ACT_START: begin
                n_org_x = i_start_x;
                n_org_y = i_start_y;
                n_cur_x = i_start_x;
                n_cur_y = i_start_y;
                n_lx    = tbt_pkg::LEAST_INIT;
                n_ly    = tbt_pkg::LEAST_INIT;
                n_gx    = tbt_pkg::GREAT_INIT;
                n_gy    = tbt_pkg::GREAT_INIT;
            end
            tbt_pkg::ACT_CHAR: begin
                if (i_char == tbt_pkg::CHAR_NEWLINE) begin
                    // newline returns to column zero, not to the origin
                    n_cur_x = '0;
                    n_cur_y = r_cur_y + line_step;
                end else if (i_char != tbt_pkg::CHAR_RETURN && in_range) begin
                    if (x1 < r_lx) n_lx = x1;
                    if (y1 < r_ly) n_ly = y1;
                    if (x2 > r_gx) n_gx = x2;
                    if (y2 > r_gy) n_gy = y2;
                    n_cur_x = r_cur_x + prod_adv;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= '0;
            r_cur_y <= '0;
            r_org_x <= '0;
            r_org_y <= '0;
            r_lx    <= tbt_pkg::LEAST_INIT;
            r_ly    <= tbt_pkg::LEAST_INIT;
            r_gx    <= tbt_pkg::GREAT_INIT;
            r_gy    <= tbt_pkg::GREAT_INIT;
        end else if (i_step) begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_org_x <= n_org_x;
            r_org_y <= n_org_y;
            r_lx    <= n_lx;
            r_ly    <= n_ly;
            r_gx    <= n_gx;
            r_gy    <= n_gy;
        end
    end

    // each axis is empty on its own when greatest is below least
    always_comb begin
        o_result = '0;
        o_result.left_x  = r_org_x;
        o_result.top_y   = r_org_y;
        o_result.final_x = r_cur_x;
        o_result.final_y = r_cur_y;
        if (r_gx >= r_lx) begin
            o_result.left_x    = r_lx;
            o_result.box_width = r_gx - r_lx + 16'd1;
        end
        if (r_gy >= r_ly) begin
            o_result.top_y      = r_ly;
            o_result.box_height = r_gy - r_ly + 16'd1;
        end
    end

endmodule

/* rtl/core/text_bounding_box_tracker.sv */
// top level of the text bounding box tracker
// Measures the pixel bounding box of a text string. Words on the slave side are
// load glyph, start string, character or finish (tuser); only a finish gives a
// result word holding the box and the final cursor. One word is taken every
// cycle: a word is registered on acceptance together with its glyph table read,
// and when stage one moves on the cursor and box update is done in one pass
// against the state registers. A finish result is loaded into the output
// register at that same edge. The slave side stalls only when a finish word
// meets a full output register that is not being drained. The glyph table is
// not cleared at reset; a character using a slot that was never loaded gives
// undefined box values. Configuration writes must be made while idle.
module text_bounding_box_tracker #(
    parameter int GLYPH_ENTRIES = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // char_code, glyph_slot, glyph_width, glyph_height, glyph_advance,
    // glyph_offset_x, glyph_offset_y, start_x, start_y
    input  logic [87:0]  i_s_tdata,
    // action
    input  logic [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // left_x, top_y, box_width, box_height, final_x, final_y
    output logic [95:0]  o_m_tdata,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [7:0]   i_cfg_data
);

    localparam int AW = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;

    tbt_pkg::t_cfg    r_cfg;
    tbt_pkg::t_action in_act;
    tbt_pkg::t_glyph  in_glyph, rd_glyph;
    logic [7:0]       in_char, in_slot, rd_idx;
    logic             s_accept, step, load_we, idx_ok;

    logic             r_v1, r_glyph_ok;
    tbt_pkg::t_action r_act;
    logic [7:0]       r_char;
    logic [15:0]      r_start_x, r_start_y;

    tbt_pkg::t_result res, r_out;
    logic             r_out_valid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale_x         <= tbt_pkg::RST_SCALE;
            r_cfg.scale_y         <= tbt_pkg::RST_SCALE;
            r_cfg.use_custom_font <= 1'b0;
            r_cfg.first_char      <= tbt_pkg::RST_FIRST_CHAR;
            r_cfg.last_char       <= tbt_pkg::RST_LAST_CHAR;
            r_cfg.line_advance    <= tbt_pkg::RST_LINE_ADV;
        end else if (i_cfg_we) begin
            case (tbt_pkg::t_cfg_reg'(i_cfg_idx))
                tbt_pkg::CFG_SCALE_X:      r_cfg.scale_x         <= i_cfg_data;
                tbt_pkg::CFG_SCALE_Y:      r_cfg.scale_y         <= i_cfg_data;
                tbt_pkg::CFG_CUSTOM_FONT:  r_cfg.use_custom_font <= i_cfg_data[0];
                tbt_pkg::CFG_FIRST_CHAR:   r_cfg.first_char      <= i_cfg_data;
                tbt_pkg::CFG_LAST_CHAR:    r_cfg.last_char       <= i_cfg_data;
                tbt_pkg::CFG_LINE_ADVANCE: r_cfg.line_advance    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign in_act   = tbt_pkg::t_action'(i_s_tuser);
    assign in_char  = i_s_tdata[7:0];
    assign in_slot  = i_s_tdata[15:8];
    // width, height, advance, offset x, offset y from the msb of the struct down
    assign in_glyph = {i_s_tdata[23:16], i_s_tdata[31:24], i_s_tdata[39:32],
                       i_s_tdata[47:40], i_s_tdata[55:48]};

    // stage one moves on unless a finish finds the output register blocked
    assign step       = r_v1 && ((r_act != tbt_pkg::ACT_FINISH) || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_v1 || step;
    assign s_accept   = i_s_tvalid && o_s_tready;

    assign rd_idx  = in_char - r_cfg.first_char;
    assign idx_ok  = 32'(rd_idx) < GLYPH_ENTRIES;
    assign load_we = s_accept && (in_act == tbt_pkg::ACT_LOAD) && (32'(in_slot) < GLYPH_ENTRIES);

    tbt_glyph_ram #(
        .ENTRIES (GLYPH_ENTRIES),
        .AW      (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (in_slot[AW-1:0]),
        .i_wdata (in_glyph),
        .i_re    (s_accept),
        .i_raddr (rd_idx[AW-1:0]),
        .o_rdata (rd_glyph)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s_accept) begin
            r_v1 <= 1'b1;
        end else if (step) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_act      <= in_act;
            r_char     <= in_char;
            r_start_x  <= i_s_tdata[71:56];
            r_start_y  <= i_s_tdata[87:72];
            r_glyph_ok <= idx_ok;
        end
    end

    tbt_box_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_act      (r_act),
        .i_char     (r_char),
        .i_start_x  (r_start_x),
        .i_start_y  (r_start_y),
        .i_glyph    (rd_glyph),
        .i_glyph_ok (r_glyph_ok),
        .i_cfg      (r_cfg),
        .o_result   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && (r_act == tbt_pkg::ACT_FINISH)) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && (r_act == tbt_pkg::ACT_FINISH)) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.final_y, r_out.final_x, r_out.box_height,
                         r_out.box_width, r_out.top_y, r_out.left_x};

`ifndef SYNTHESIS
    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(step && (r_act == tbt_pkg::ACT_FINISH)))
        else $error("result word without a finish");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> r_v1 && (r_act == tbt_pkg::ACT_FINISH) && r_out_valid && !i_m_tready)
        else $error("input stalled without a blocked finish");

    a_stage_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !step |=> r_v1 && $stable(r_act))
        else $error("pending word lost from stage one");
`endif

endmodule

/* test/testbench.sv */
// stimulus and checking of the text bounding box tracker against its own predictor
`timescale 1ns / 1ps

module testbench;

    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 100;
    localparam int MAX_CHARS     = 12;
    localparam int SETTLE_CYCLES = 4;

    // one word of the slave side, fields unpacked
    typedef struct {
        tbt_pkg::t_action   act;
        logic [7:0]         code;
        logic [7:0]         slot;
        logic [7:0]         gw;
        logic [7:0]         gh;
        logic [7:0]         gadv;
        logic signed [7:0]  gox;
        logic signed [7:0]  goy;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
    } t_word;

    // code doubles as glyph slot on loads; want only counts where typed is set
    typedef struct packed {
        logic [1:0]       seg;
        tbt_pkg::t_action act;
        logic [7:0]       code;
        tbt_pkg::t_glyph  glyph;
        logic [15:0]      sx;
        logic [15:0]      sy;
        logic             typed;
        tbt_pkg::t_result want;
    } t_row;

    localparam t_row DIRECTED [23] = '{
        // empty box straight after reset
        '{2'd0, tbt_pkg::ACT_FINISH, 8'h00, 40'h0, 16'h0000, 16'h0000, 1'b1,
          {16'h0000, 16'h0000, 16'd0, 16'd0, 16'h0000, 16'h0000}},
        '{2'd0, tbt_pkg::ACT_START,  8'h00, 40'h0, 16'h0000, 16'h0000, 1'b0, 96'h0},
        '{2'd0, tbt_pkg::ACT_CHAR,   8'h41, 40'h0, 16'h0000, 16'h0000, 1'b0, 96'h0},
        '{2'd0, tbt_pkg::ACT_CHAR,   tbt_pkg::CHAR_RETURN,
          40'h0, 16'h0000, 16'h0000, 1'b0, 96'h0},
        '{2'd0, tbt_pkg::ACT_CHAR,   tbt_pkg::CHAR_NEWLINE,
          40'h0, 16'h0000, 16'h0000, 1'b0, 96'h0},
        '{2'd0, tbt_pkg::ACT_CHAR,   8'h00, 40'h0, 16'h0000, 16'h0000, 1'b0, 96'h0},
        '{2'd0, tbt_pkg::ACT_FINISH, 8'h00, 40'h0, 16'h0000, 16'h0000, 1'b1,
          {16'h0000, 16'h0000, 16'd6, 16'd16, 16'h0006, 16'h0008}},
        // cursor at the corner: x wraps, so that axis stays empty
        '{2'd0, tbt_pkg::ACT_START,  8'h00, 40'h0, 16'h7FFF, 16'h8000, 1'b0, 96'h0},
        '{2'd0, tbt_pkg::ACT_CHAR,   8'hFF, 40'h0, 16'h0000, 16'h0000, 1'b0, 96'h0},
        '{2'd0, tbt_pkg::ACT_FINISH, 8'h00, 40'h0, 16'h0000, 16'h0000, 1'b1,
          {16'h7FFF, 16'h8000, 16'd0, 16'd8, 16'h8005, 16'h8000}},
        '{2'd0, tbt_pkg::ACT_FINISH, 8'h00, 40'h0, 16'h0000, 16'h0000, 1'b1,
          {16'h7FFF, 16'h8000, 16'd0, 16'd8, 16'h8005, 16'h8000}},
        '{2'd0, tbt_pkg::ACT_LOAD,   8'h00, 40'hFF_FF_FF_80_7F,
          16'h0000, 16'h0000, 1'b0, 96'h0},
        '{2'd0, tbt_pkg::ACT_LOAD,   8'hFF, 40'h01_01_00_7F_80,
          16'h0000, 16'h0000, 1'b0, 96'h0},
        // custom font, full code range, largest scales
        '{2'd1, tbt_pkg::ACT_START,  8'h00, 40'h0, 16'h1234, 16'hFFF0, 1'b0, 96'h0},
        '{2'd1, tbt_pkg::ACT_CHAR,   8'h00, 40'h0, 16'h0000, 16'h0000, 1'b0, 96'h0},
        '{2'd1, tbt_pkg::ACT_CHAR,   8'hFF, 40'h0, 16'h0000, 16'h0000, 1'b0, 96'h0},
        '{2'd1, tbt_pkg::ACT_CHAR,   tbt_pkg::CHAR_RETURN,
          40'h0, 16'h0000, 16'h0000, 1'b0, 96'h0},
        '{2'd1, tbt_pkg::ACT_CHAR,   tbt_pkg::CHAR_NEWLINE,
          40'h0, 16'h0000, 16'h0000, 1'b0, 96'h0},
        '{2'd1, tbt_pkg::ACT_FINISH, 8'h00, 40'h0, 16'h0000, 16'h0000, 1'b0, 96'h0},
        // first code above last code: every glyph is skipped
        '{2'd2, tbt_pkg::ACT_CHAR,   8'h00, 40'h0, 16'h0000, 16'h0000, 1'b0, 96'h0},
        '{2'd2, tbt_pkg::ACT_CHAR,   8'hFF, 40'h0, 16'h0000, 16'h0000, 1'b0, 96'h0},
        '{2'd2, tbt_pkg::ACT_CHAR,   tbt_pkg::CHAR_NEWLINE,
          40'h0, 16'h0000, 16'h0000, 1'b0, 96'h0},
        '{2'd2, tbt_pkg::ACT_FINISH, 8'h00, 40'h0, 16'h0000, 16'h0000, 1'b0, 96'h0}
    };

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [87:0]       s_tdata  = '0;
    logic [1:0]        s_tuser  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [95:0]       m_tdata;
    logic              cfg_we   = 1'b0;
    tbt_pkg::t_cfg_reg cfg_idx  = tbt_pkg::CFG_SCALE_X;
    logic [7:0]        cfg_data = '0;

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int errors        = 0;

    // predictor state
    tbt_pkg::t_cfg      cfg_now;
    logic signed [15:0] cur_x = '0, cur_y = '0, org_x = '0, org_y = '0;
    logic signed [15:0] lo_x = tbt_pkg::LEAST_INIT, lo_y = tbt_pkg::LEAST_INIT;
    logic signed [15:0] hi_x = tbt_pkg::GREAT_INIT, hi_y = tbt_pkg::GREAT_INIT;
    tbt_pkg::t_glyph    glyph_mem [256];
    bit                 loaded [256];
    tbt_pkg::t_result   pending_boxes [$];

    text_bounding_box_tracker dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    function automatic logic [87:0] pack_word(input t_word w);
        return {w.sy, w.sx, w.goy, w.gox, w.gadv, w.gh, w.gw, w.slot, w.code};
    endfunction

    function automatic t_word rand_word();
        t_word w;
        w.act  = tbt_pkg::t_action'($urandom_range(3));
        w.code = 8'($urandom);
        w.slot = 8'($urandom);
        w.gw   = 8'($urandom);
        w.gh   = 8'($urandom);
        w.gadv = 8'($urandom);
        w.gox  = 8'($urandom);
        w.goy  = 8'($urandom);
        w.sx   = 16'($urandom);
        w.sy   = 16'($urandom);
        return w;
    endfunction

    // cursor and box update for one accepted word; gives is set on a finish
    function automatic void trace_word(input t_word w, output logic gives,
                                       output tbt_pkg::t_result r);
        int                 sx, sy, lead;
        logic signed [15:0] x1, y1, x2, y2;
        tbt_pkg::t_glyph    g;
        logic               grow;
        sx    = cfg_now.scale_x;
        sy    = cfg_now.scale_y;
        gives = 1'b0;
        r     = '0;
        grow  = 1'b0;
        case (w.act)
            tbt_pkg::ACT_LOAD: begin
                glyph_mem[w.slot] = {w.gw, w.gh, w.gadv, w.gox, w.goy};
                loaded[w.slot]    = 1'b1;
            end
            tbt_pkg::ACT_START: begin
                org_x = w.sx;
                org_y = w.sy;
                cur_x = w.sx;
                cur_y = w.sy;
                lo_x  = tbt_pkg::LEAST_INIT;
                lo_y  = tbt_pkg::LEAST_INIT;
                hi_x  = tbt_pkg::GREAT_INIT;
                hi_y  = tbt_pkg::GREAT_INIT;
            end
            tbt_pkg::ACT_CHAR: begin
                if (w.code == tbt_pkg::CHAR_NEWLINE) begin
                    // back to column zero, not to the origin
                    lead  = cfg_now.use_custom_font ? int'(cfg_now.line_advance)
                                                    : int'(tbt_pkg::CELL_H);
                    cur_x = '0;
                    cur_y = cur_y + 16'(sy * lead);
                end else if (w.code == tbt_pkg::CHAR_RETURN) begin
                    grow = 1'b0;
                end else if (!cfg_now.use_custom_font) begin
                    x1    = cur_x;
                    y1    = cur_y;
                    x2    = cur_x + 16'(sx * int'(tbt_pkg::CELL_W) - 1);
                    y2    = cur_y + 16'(sy * int'(tbt_pkg::CELL_H) - 1);
                    cur_x = cur_x + 16'(sx * int'(tbt_pkg::CELL_W));
                    grow  = 1'b1;
                end else if (w.code >= cfg_now.first_char && w.code <= cfg_now.last_char) begin
                    g     = glyph_mem[8'(w.code - cfg_now.first_char)];
                    x1    = cur_x + 16'($signed(g.ox) * sx);
                    y1    = cur_y + 16'($signed(g.oy) * sy);
                    x2    = x1 + 16'(int'(g.w) * sx - 1);
                    y2    = y1 + 16'(int'(g.h) * sy - 1);
                    cur_x = cur_x + 16'(int'(g.adv) * sx);
                    grow  = 1'b1;
                end
                if (grow) begin
                    if (x1 < lo_x) lo_x = x1;
                    if (y1 < lo_y) lo_y = y1;
                    if (x2 > hi_x) hi_x = x2;
                    if (y2 > hi_y) hi_y = y2;
                end
            end
            tbt_pkg::ACT_FINISH: begin
                gives        = 1'b1;
                r.left_x     = org_x;
                r.top_y      = org_y;
                r.box_width  = '0;
                r.box_height = '0;
                // each axis is empty on its own
                if (hi_x >= lo_x) begin
                    r.left_x    = lo_x;
                    r.box_width = hi_x - lo_x + 16'd1;
                end
                if (hi_y >= lo_y) begin
                    r.top_y      = lo_y;
                    r.box_height = hi_y - lo_y + 16'd1;
                end
                r.final_x = cur_x;
                r.final_y = cur_y;
            end
            default: begin
            end
        endcase
    endfunction

    task automatic push_word(input t_word w);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_word(w);
        s_tuser  <= w.act;
        @(posedge clk);
        while (s_tready !== 1'b1) @(posedge clk);
    endtask

    task automatic drive(input t_word w);
        logic             gives;
        tbt_pkg::t_result r;
        push_word(w);
        trace_word(w, gives, r);
        if (gives) pending_boxes.push_back(r);
    endtask

    // a custom glyph is only drawn once its slot holds metrics
    task automatic send_char(input t_word w);
        t_word      fill;
        logic [7:0] idx;
        idx = w.code - cfg_now.first_char;
        if (cfg_now.use_custom_font && w.code != tbt_pkg::CHAR_NEWLINE &&
            w.code != tbt_pkg::CHAR_RETURN &&
            w.code >= cfg_now.first_char && w.code <= cfg_now.last_char && !loaded[idx]) begin
            fill      = rand_word();
            fill.act  = tbt_pkg::ACT_LOAD;
            fill.slot = idx;
            drive(fill);
        end
        drive(w);
    endtask

    function automatic logic [7:0] pick_code();
        int pick;
        pick = $urandom_range(99);
        if (pick < 12) return tbt_pkg::CHAR_NEWLINE;
        if (pick < 17) return tbt_pkg::CHAR_RETURN;
        if (cfg_now.use_custom_font && pick < 80 && cfg_now.first_char <= cfg_now.last_char)
            return 8'($urandom_range(cfg_now.first_char, cfg_now.last_char));
        return 8'($urandom_range(255));
    endfunction

    task automatic run_phase(input int quota);
        int    sent;
        int    n;
        int    pick;
        t_word w;
        sent = 0;
        while (sent < quota) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                w     = rand_word();
                w.act = tbt_pkg::ACT_START;
                if ($urandom_range(1)) begin
                    w.sx = 16'($urandom_range(2000) - 1000);
                    w.sy = 16'($urandom_range(2000) - 1000);
                end
                drive(w);
                n = $urandom_range(MAX_CHARS);
                repeat (n) begin
                    w      = rand_word();
                    w.act  = tbt_pkg::ACT_CHAR;
                    w.code = pick_code();
                    send_char(w);
                end
                w     = rand_word();
                w.act = tbt_pkg::ACT_FINISH;
                drive(w);
                sent += n + 2;
            end else if (pick < 90) begin
                w     = rand_word();
                w.act = tbt_pkg::ACT_LOAD;
                drive(w);
                sent++;
            end else begin
                // stray word of any kind, outside a well-formed string
                w = rand_word();
                if (w.act == tbt_pkg::ACT_CHAR) send_char(w);
                else drive(w);
                sent++;
            end
        end
    endtask

    task automatic put_reg(input tbt_pkg::t_cfg_reg idx, input logic [7:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic apply_settings(input tbt_pkg::t_cfg c);
        put_reg(tbt_pkg::CFG_SCALE_X, c.scale_x);
        put_reg(tbt_pkg::CFG_SCALE_Y, c.scale_y);
        put_reg(tbt_pkg::CFG_CUSTOM_FONT, {7'd0, c.use_custom_font});
        put_reg(tbt_pkg::CFG_FIRST_CHAR, c.first_char);
        put_reg(tbt_pkg::CFG_LAST_CHAR, c.last_char);
        put_reg(tbt_pkg::CFG_LINE_ADVANCE, c.line_advance);
        cfg_we  <= 1'b0;
        cfg_now  = c;
    endtask

    // loads and characters give no word, so let the pipe empty after the last result
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_boxes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic tbt_pkg::t_cfg directed_setup(input int seg);
        case (seg)
            0: return '{scale_x: tbt_pkg::RST_SCALE, scale_y: tbt_pkg::RST_SCALE,
                        use_custom_font: 1'b0,
                        first_char: tbt_pkg::RST_FIRST_CHAR,
                        last_char: tbt_pkg::RST_LAST_CHAR,
                        line_advance: tbt_pkg::RST_LINE_ADV};
            1: return '{scale_x: 8'd255, scale_y: 8'd255, use_custom_font: 1'b1,
                        first_char: 8'd0, last_char: 8'd255, line_advance: 8'd255};
            default: return '{scale_x: 8'd255, scale_y: 8'd255, use_custom_font: 1'b1,
                              first_char: 8'd200, last_char: 8'd100, line_advance: 8'd255};
        endcase
    endfunction

    function automatic tbt_pkg::t_cfg phase_setup(input int p);
        tbt_pkg::t_cfg c;
        c.scale_x         = ($urandom_range(3) == 0) ? 8'($urandom_range(1, 255))
                                                     : 8'($urandom_range(1, 4));
        c.scale_y         = ($urandom_range(3) == 0) ? 8'($urandom_range(1, 255))
                                                     : 8'($urandom_range(1, 4));
        c.use_custom_font = 1'($urandom_range(1));
        c.first_char      = 8'($urandom_range(127));
        c.last_char       = 8'($urandom_range(c.first_char, 255));
        c.line_advance    = 8'($urandom_range(255));
        case (p)
            1: begin
                c.use_custom_font = 1'b0;
                c.scale_x         = 8'd255;
                c.scale_y         = 8'd255;
            end
            2: begin
                c = '{scale_x: 8'd1, scale_y: 8'd1, use_custom_font: 1'b1,
                      first_char: 8'd0, last_char: 8'd255, line_advance: 8'd0};
            end
            3: begin
                c = '{scale_x: 8'd255, scale_y: 8'd255, use_custom_font: 1'b1,
                      first_char: 8'd32, last_char: 8'd126, line_advance: 8'd255};
            end
            5: begin
                c.use_custom_font = 1'b1;
                c.first_char      = 8'd255;
                c.last_char       = 8'd0;
            end
            6: begin
                c.use_custom_font = 1'b1;
            end
            default: begin
                c.line_advance = c.line_advance;
            end
        endcase
        return c;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endfunction

    // result side: random backpressure, every accepted word checked in order
    initial begin
        tbt_pkg::t_result want;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid === 1'b1 && m_tready) begin
                if (pending_boxes.size() == 0) begin
                    $error("result word with nothing expected: %h", m_tdata);
                    errors++;
                end else begin
                    want = pending_boxes.pop_front();
                    check_field("left_x", want.left_x, m_tdata[15:0]);
                    check_field("top_y", want.top_y, m_tdata[31:16]);
                    check_field("box_width", want.box_width, m_tdata[47:32]);
                    check_field("box_height", want.box_height, m_tdata[63:48]);
                    check_field("final_x", want.final_x, m_tdata[79:64]);
                    check_field("final_y", want.final_y, m_tdata[95:80]);
                end
            end
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    initial begin
        int               seg_now;
        t_word            w;
        logic             gives;
        tbt_pkg::t_result r;
        cfg_now = directed_setup(0);
        seg_now = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        apply_settings(directed_setup(0));

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].seg != seg_now) begin
                seg_now = DIRECTED[i].seg;
                wait_idle();
                apply_settings(directed_setup(seg_now));
            end
            w.act  = DIRECTED[i].act;
            w.code = DIRECTED[i].code;
            w.slot = DIRECTED[i].code;
            {w.gw, w.gh, w.gadv, w.gox, w.goy} = DIRECTED[i].glyph;
            w.sx   = DIRECTED[i].sx;
            w.sy   = DIRECTED[i].sy;
            push_word(w);
            trace_word(w, gives, r);
            if (gives) pending_boxes.push_back(DIRECTED[i].typed ? DIRECTED[i].want : r);
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            apply_settings(phase_setup(p));
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 87; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 87; end
                default: begin src_idle_pct = 7; snk_stall_pct = 7; end
            endcase
            run_phase(PHASE_ITEMS);
        end

        wait_idle();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #2000000;
        $error("timeout with %0d result words outstanding", pending_boxes.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
